[design/assert_macros.svh]
// Assertion macros shared by the convolution RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, b)
`define ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[design/rgbc_pkg.sv]
// Types and constants of the RGB 3x3 convolution block.
// No dependencies.
package rgbc_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KSIZE         = 3;
    localparam int COEF_BITS     = 16;
    localparam int COEF_FRAC     = 12;
    localparam int CHAN_BITS     = 8;
    localparam int PROD_BITS     = 24;
    localparam int SUM_BITS      = 28;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam int ITEM_BITS     = 23;
    localparam int OUT_BITS      = 23;

    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_MID = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT   = 3'd4;

    localparam logic [CFG_DATA_BITS-1:0] COEF_MID_RST = 48'h0000_1000_0000;

    typedef struct packed {
        logic [CHAN_BITS-1:0] b;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] r;
    } t_pix;

    typedef t_pix [KSIZE-1:0] t_col;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] b;
        logic signed [SUM_BITS-1:0] g;
        logic signed [SUM_BITS-1:0] r;
    } t_rgb_sum;

    typedef struct packed {
        logic top;
        logic bot;
    } t_clamp;

    typedef struct packed {
        logic   x_first;
        logic   x_last;
        t_clamp row;
        logic   done;
    } t_flags;
endpackage

[design/rgbc_ifs.sv]
// Channel interfaces of the convolution block: pixels in, sums out, config writes.
// Depends on rgbc_pkg.
interface rgbc_pix_if import rgbc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [CHAN_BITS-1:0] red_in;
    logic [CHAN_BITS-1:0] green_in;
    logic [CHAN_BITS-1:0] blue_in;
    modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface rgbc_sum_if import rgbc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] red_sum;
    logic signed [SUM_BITS-1:0] green_sum;
    logic signed [SUM_BITS-1:0] blue_sum;
    logic                       frame_done;
    modport source (output valid, red_sum, green_sum, blue_sum, frame_done, input ready);
    modport sink   (input valid, red_sum, green_sum, blue_sum, frame_done, output ready);
endinterface

interface rgbc_cfg_if import rgbc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/rgbc_line_mem.sv]
// Two-row line store: one entry per column holds the older and newer row pixel.
// Depends on rgbc_pkg.
module rgbc_line_mem import rgbc_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_line         o_rd_data,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line         i_wr_data
);
    t_line r_mem [MAX_WIDTH];
    t_line r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
endmodule

[design/rgbc_cell.sv]
// One window column: holds three pixels, hands them to the next column, and
// weights a chosen column with its kernel column. Depends on rgbc_pkg.
module rgbc_cell import rgbc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic                          i_shift,
    input  t_col                          i_col,
    output t_col                          o_col,
    input  t_col                          i_src,
    input  t_clamp                        i_clamp,
    input  logic [KSIZE*COEF_BITS-1:0]    i_coef,
    output t_rgb_sum                      o_sum
);
    t_col r_col;
    logic signed [PROD_BITS-1:0] r_prod [KSIZE][3];
    logic signed [PROD_BITS-1:0] n_prod [KSIZE][3];
    t_rgb_sum r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en && i_shift) begin
            r_col <= i_col;
        end
    end
    assign o_col = r_col;

    always_comb begin
        t_pix                        px;
        logic signed [PROD_BITS-1:0] cf;
        for (int j = 0; j < KSIZE; j++) begin
            px = i_src[j];
            // clamp rows at the top and bottom edges to the centre row
            if ((j == 0 && i_clamp.top) || (j == KSIZE-1 && i_clamp.bot)) begin
                px = i_src[(KSIZE-1)/2];
            end
            cf = PROD_BITS'(signed'(i_coef[j*COEF_BITS +: COEF_BITS]));
            n_prod[j][0] = PROD_BITS'(cf * signed'({1'b0, px.r}));
            n_prod[j][1] = PROD_BITS'(cf * signed'({1'b0, px.g}));
            n_prod[j][2] = PROD_BITS'(cf * signed'({1'b0, px.b}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_sum.r <= SUM_BITS'(r_prod[0][0]) + SUM_BITS'(r_prod[1][0])
                       + SUM_BITS'(r_prod[2][0]);
            r_sum.g <= SUM_BITS'(r_prod[0][1]) + SUM_BITS'(r_prod[1][1])
                       + SUM_BITS'(r_prod[2][1]);
            r_sum.b <= SUM_BITS'(r_prod[0][2]) + SUM_BITS'(r_prod[1][2])
                       + SUM_BITS'(r_prod[2][2]);
        end
    end
    assign o_sum = r_sum;
endmodule

[design/rgb_convolution_clamped_edges.sv]
// 3x3 convolution of an RGB raster stream with clamp-to-edge borders.
// Depends on rgbc_pkg, rgbc_ifs, rgbc_line_mem, rgbc_cell, assert_macros.svh.
//
// Takes one pixel request per clock while ready is high and gives one sum request per
// clock once the pipeline is full, unless the output stalls; each result passes the
// stage 1, cell and output registers after the request that completes its window,
// W+1 requests after its own pixel. Three column cells shift the window one column per
// request; a two-row line store (one read and one write port, read registered) supplies
// the rows above. Sums are exact Q.12 values. After the last pixel send W+1 flush
// requests to drain. Ready drops only while both output stages are full.
module rgb_convolution_clamped_edges import rgbc_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgbc_pix_if.sink    i_pix,
    rgbc_sum_if.source  o_sum,
    rgbc_cfg_if.sink    i_cfg
);
    `include "assert_macros.svh"

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMPW  = 24;
    localparam int RST_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // configuration; the effective geometry is taken at the write itself
    logic [CFG_DATA_BITS-1:0] r_coef [KSIZE];
    logic [FW_BITS-1:0]       r_w;
    logic [FH_BITS-1:0]       r_h;
    logic [ITEM_BITS-1:0]     r_p;
    logic [FW_BITS-1:0]       cfg_w;
    logic [FH_BITS-1:0]       cfg_h;

    assign i_cfg.ready = 1'b1;

    // width 0 acts as 1, a width above MAX_WIDTH as MAX_WIDTH; height 0 acts as 1
    always_comb begin
        cfg_w = i_cfg.data[FW_BITS-1:0];
        if (cfg_w == '0) begin
            cfg_w = FW_BITS'(1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            cfg_w = FW_BITS'(MAX_WIDTH);
        end
        cfg_h = i_cfg.data[FH_BITS-1:0];
        if (cfg_h == '0) begin
            cfg_h = FH_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= '0;
            r_coef[1] <= COEF_MID_RST;
            r_coef[2] <= '0;
            r_w       <= FW_BITS'(RST_W);
            r_h       <= FH_BITS'(768);
            r_p       <= ITEM_BITS'(RST_W * 768);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COEF_TOP: r_coef[0] <= i_cfg.data;
                REG_COEF_MID: r_coef[1] <= i_cfg.data;
                REG_COEF_BOT: r_coef[2] <= i_cfg.data;
                REG_WIDTH: begin
                    r_w <= cfg_w;
                    r_p <= ITEM_BITS'(cfg_w) * ITEM_BITS'(r_h);
                end
                REG_HEIGHT: begin
                    r_h <= cfg_h;
                    r_p <= ITEM_BITS'(r_w) * ITEM_BITS'(cfg_h);
                end
                default:      ;
            endcase
        end
    end

    // pipeline enable and output stages
    logic     en;
    logic     r_out_v, r_skid_v;
    t_rgb_sum r_out_s, r_skid_s;
    logic     r_out_d, r_skid_d;
    logic     r_v4, r_done4;
    t_rgb_sum res;

    assign en          = !r_skid_v;
    assign i_pix.ready = en;

    // stage 0: counters
    logic [ITEM_BITS-1:0] r_items, n_items;
    logic [AW-1:0]        r_c, n_c;
    logic [OUT_BITS-1:0]  r_n, n_n;
    logic [AW-1:0]        r_x, n_x;
    logic [FH_BITS-1:0]   r_y, n_y;
    logic                 acc, below_p, is_pixel, process, emit, done;
    t_flags               flags0;

    assign acc      = i_pix.valid && i_pix.ready;
    assign below_p  = r_items < r_p;
    assign is_pixel = !i_pix.cmd && below_p;
    // drop an early flush
    assign process  = acc && !(i_pix.cmd && below_p);
    assign emit     = r_items >= (ITEM_BITS'(r_w) + ITEM_BITS'(1));
    assign done     = (ITEM_BITS'(r_n) + ITEM_BITS'(1)) >= r_p;

    always_comb begin
        flags0.x_first = r_x == '0;
        flags0.x_last  = (CMPW'(r_x) + CMPW'(1)) >= CMPW'(r_w);
        flags0.row.top = r_y == '0;
        flags0.row.bot = (CMPW'(r_y) + CMPW'(1)) >= CMPW'(r_h);
        flags0.done    = done;
    end

    always_comb begin
        n_items = r_items;
        n_c     = r_c;
        n_n     = r_n;
        n_x     = r_x;
        n_y     = r_y;
        if (process) begin
            if (r_items != '1) begin
                n_items = r_items + ITEM_BITS'(1);
            end
            n_c = ((CMPW'(r_c) + CMPW'(1)) >= CMPW'(r_w)) ? '0 : r_c + AW'(1);
            if (emit) begin
                if (done) begin
                    n_items = '0;
                    n_c     = '0;
                    n_n     = '0;
                    n_x     = '0;
                    n_y     = '0;
                end else begin
                    n_n = r_n + OUT_BITS'(1);
                    if (flags0.x_last) begin
                        n_x = '0;
                        n_y = r_y + FH_BITS'(1);
                    end else begin
                        n_x = r_x + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items <= '0;
            r_c     <= '0;
            r_n     <= '0;
            r_x     <= '0;
            r_y     <= '0;
        end else begin
            r_items <= n_items;
            r_c     <= n_c;
            r_n     <= n_n;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

    // stage 1: line store read, forward the write of the previous request
    logic        r_v1, r_pix1, r_emit1;
    logic [AW-1:0] r_c1;
    t_pix        r_data1;
    t_flags      r_flags1;
    logic        r_fwd;
    t_line       r_fwd_d;
    t_line       mem_q, rd1, wr1;
    t_pix        bot1;

    rgbc_line_mem #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_line (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_rd_addr (r_c),
        .o_rd_data (mem_q),
        .i_we      (en && r_v1 && r_pix1),
        .i_wr_addr (r_c1),
        .i_wr_data (wr1)
    );

    assign rd1       = r_fwd ? r_fwd_d : mem_q;
    assign wr1.older = rd1.newer;
    assign wr1.newer = r_data1;
    assign bot1      = r_pix1 ? r_data1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= process;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pix1     <= is_pixel;
            r_emit1    <= emit;
            r_c1       <= r_c;
            r_data1.r  <= i_pix.red_in;
            r_data1.g  <= i_pix.green_in;
            r_data1.b  <= i_pix.blue_in;
            r_flags1   <= flags0;
            r_fwd      <= r_v1 && r_pix1 && (r_c1 == r_c);
            r_fwd_d    <= wr1;
        end
    end

    // stage 2: window of column cells
    logic   r_v2, r_v3;
    t_flags r_flags2;
    logic   r_done3;
    t_col   new_col;
    t_col   cols [KSIZE];
    t_col   srcs [KSIZE];
    t_rgb_sum csum [KSIZE];

    assign new_col[0] = rd1.older;
    assign new_col[1] = rd1.newer;
    assign new_col[2] = bot1;

    assign srcs[0] = r_flags2.x_first ? cols[1] : cols[0];
    assign srcs[1] = cols[1];
    assign srcs[2] = r_flags2.x_last  ? cols[1] : cols[2];

    for (genvar k = 0; k < KSIZE; k++) begin : g_cell
        logic [KSIZE*COEF_BITS-1:0] kcoef;
        for (genvar j = 0; j < KSIZE; j++) begin : g_cf
            assign kcoef[j*COEF_BITS +: COEF_BITS] = r_coef[j][k*COEF_BITS +: COEF_BITS];
        end
        rgbc_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_shift (r_v1),
            .i_col   ((k == KSIZE-1) ? new_col : cols[(k+1) % KSIZE]),
            .o_col   (cols[k]),
            .i_src   (srcs[k]),
            .i_clamp (r_flags2.row),
            .i_coef  (kcoef),
            .o_sum   (csum[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1 && r_emit1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flags2 <= r_flags1;
            r_done3  <= r_flags2.done;
            r_done4  <= r_done3;
        end
    end

    // stage 4: add column sums, then output register with skid
    always_comb begin
        res.r = csum[0].r + csum[1].r + csum[2].r;
        res.g = csum[0].g + csum[1].g + csum[2].g;
        res.b = csum[0].b + csum[1].b + csum[2].b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_sum.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_v4;
            end
        end else if (r_v4 && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_sum.ready) begin
            r_out_s <= r_skid_v ? r_skid_s : res;
            r_out_d <= r_skid_v ? r_skid_d : r_done4;
        end else if (en) begin
            r_skid_s <= res;
            r_skid_d <= r_done4;
        end
    end

    assign o_sum.valid      = r_out_v;
    assign o_sum.red_sum    = r_out_s.r;
    assign o_sum.green_sum  = r_out_s.g;
    assign o_sum.blue_sum   = r_out_s.b;
    assign o_sum.frame_done = r_out_d;

    `ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `ASSERT_IMP(a_pos_restarts, i_clk, i_rst_n, r_n == '0, (r_x == '0) && (r_y == '0))
    `ASSERT_NXT(a_done_clears, i_clk, i_rst_n, process && emit && done,
                (r_items == '0) && (r_n == '0))
endmodule
